// File: src/mmsn_pkg.sv
// Shared types and constants of the min/max score normalizer.
// Depends on nothing; mmsn_front, mmsn_back and the top level import it.
package mmsn_pkg;

    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_SCORE_BITS  = 32;

    localparam int SAMPLE_BITS    = 32;
    localparam int INDEX_BITS     = 6;
    localparam int NORM_BITS      = 17;
    localparam int DIV_STEPS      = 17;
    localparam int STEP_BITS      = 5;

    // 1.0 in unsigned Q1.16
    localparam logic [NORM_BITS-1:0] FRAC_ONE = NORM_BITS'(65536);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_value;
        logic                          mark_worst;
        logic                          end_of_set;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] entry_index;
        logic [NORM_BITS-1:0]  normalized_score;
        logic                  last_result;
    } out_item_t;

    // Back end tells the front end that a store bank has been emitted.
    typedef struct packed {
        logic valid;
        logic bank;
    } done_t;

endpackage

// File: src/mmsn_front.sv
// Front end: takes input words, writes the score store, tracks min/max.
// Depends on mmsn_pkg; feeds mmsn_jobq and the store inside mmsn_back.
module mmsn_front #(
    parameter int MAX_ENTRIES = mmsn_pkg::DEF_MAX_ENTRIES,
    parameter int SCORE_BITS  = mmsn_pkg::DEF_SCORE_BITS,
    parameter int IDX_W       = $clog2(MAX_ENTRIES),
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  mmsn_pkg::in_item_t           item,
    input  logic                         high_is_good,
    // store write port
    output logic                         wr_en,
    output logic [IDX_W:0]               wr_addr,
    output logic [SCORE_BITS:0]          wr_data,
    // job handoff
    output logic                         job_push,
    input  logic                         job_full,
    output logic                         job_bank,
    output logic [CNT_W-1:0]             job_count,
    output logic signed [SCORE_BITS-1:0] job_min,
    output logic signed [SCORE_BITS-1:0] job_max,
    output logic                         job_hig,
    input  mmsn_pkg::done_t              done
);
    import mmsn_pkg::*;

    localparam int WIDE_W = (SCORE_BITS > SAMPLE_BITS) ? SCORE_BITS : SAMPLE_BITS;
    localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
    localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

    logic                         bank_reg,  bank_next;
    logic [1:0]                   busy_reg,  busy_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic signed [SCORE_BITS-1:0] min_reg,   min_next;
    logic signed [SCORE_BITS-1:0] max_reg,   max_next;

    logic                         accept;
    logic                         room;
    logic signed [WIDE_W-1:0]     wide;
    logic signed [WIDE_W-1:0]     sat;
    logic signed [SCORE_BITS-1:0] score;
    logic                         inf;
    logic                         track;
    logic signed [SCORE_BITS-1:0] min_upd;
    logic signed [SCORE_BITS-1:0] max_upd;

    // saturate the 32-bit sample into the score range
    assign wide  = WIDE_W'(item.sample_value);
    assign sat   = (wide > WIDE_W'(SCORE_MAX)) ? WIDE_W'(SCORE_MAX) :
                   (wide < WIDE_W'(SCORE_MIN)) ? WIDE_W'(SCORE_MIN) : wide;
    assign score = item.mark_worst ? '0 : sat[SCORE_BITS-1:0];
    assign inf   = item.mark_worst && !high_is_good;
    assign track = !inf;

    assign min_upd = (track && score <= min_reg) ? score : min_reg;
    assign max_upd = (track && score >= max_reg) ? score : max_reg;

    assign full   = busy_reg[bank_reg] || job_full;
    assign accept = push && !full;
    assign room   = count_reg < CNT_W'(MAX_ENTRIES);

    assign wr_en   = accept && room;
    assign wr_addr = {bank_reg, count_reg[IDX_W-1:0]};
    assign wr_data = {inf, score};

    assign job_push  = accept && item.end_of_set;
    assign job_bank  = bank_reg;
    assign job_count = room ? count_reg + CNT_W'(1) : count_reg;
    assign job_min   = room ? min_upd : min_reg;
    assign job_max   = room ? max_upd : max_reg;
    assign job_hig   = high_is_good;

    always_comb
    begin
        bank_next  = bank_reg;
        busy_next  = busy_reg;
        count_next = count_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        if (done.valid)
        begin
            busy_next[done.bank] = 1'b0;
        end
        if (accept)
        begin
            if (item.end_of_set)
            begin
                // hand the bank over and start a fresh set in the other one
                busy_next[bank_reg] = 1'b1;
                bank_next  = !bank_reg;
                count_next = '0;
                min_next   = SCORE_MAX;
                max_next   = SCORE_MIN;
            end
            else if (room)
            begin
                count_next = count_reg + CNT_W'(1);
                min_next   = min_upd;
                max_next   = max_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
            count_reg <= '0;
            min_reg   <= SCORE_MAX;
            max_reg   <= SCORE_MIN;
        end
        else
        begin
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
            count_reg <= count_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

endmodule

// File: src/mmsn_jobq.sv
// Two-deep queue of finished sets between front and back end.
// Depends on nothing but its parameters.
module mmsn_jobq #(
    parameter int SCORE_BITS = 32,
    parameter int CNT_W      = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         in_bank,
    input  logic [CNT_W-1:0]             in_count,
    input  logic signed [SCORE_BITS-1:0] in_min,
    input  logic signed [SCORE_BITS-1:0] in_max,
    input  logic                         in_hig,
    input  logic                         pop,
    output logic                         empty,
    output logic                         out_bank,
    output logic [CNT_W-1:0]             out_count,
    output logic signed [SCORE_BITS-1:0] out_min,
    output logic signed [SCORE_BITS-1:0] out_max,
    output logic                         out_hig
);
    logic                         bank_q  [2];
    logic [CNT_W-1:0]             count_q [2];
    logic signed [SCORE_BITS-1:0] min_q   [2];
    logic signed [SCORE_BITS-1:0] max_q   [2];
    logic                         hig_q   [2];

    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = fill_reg == 2'd2;
    assign empty   = fill_reg == 2'd0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    assign out_bank  = bank_q[rd_ptr_reg];
    assign out_count = count_q[rd_ptr_reg];
    assign out_min   = min_q[rd_ptr_reg];
    assign out_max   = max_q[rd_ptr_reg];
    assign out_hig   = hig_q[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            bank_q[wr_ptr_reg]  <= in_bank;
            count_q[wr_ptr_reg] <= in_count;
            min_q[wr_ptr_reg]   <= in_min;
            max_q[wr_ptr_reg]   <= in_max;
            hig_q[wr_ptr_reg]   <= in_hig;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// File: src/mmsn_back.sv
// Back end: two-bank score store, per-entry normalize and radix-2 divide,
// result register. Depends on mmsn_pkg; reads jobs from mmsn_jobq.
module mmsn_back #(
    parameter int MAX_ENTRIES = mmsn_pkg::DEF_MAX_ENTRIES,
    parameter int SCORE_BITS  = mmsn_pkg::DEF_SCORE_BITS,
    parameter int IDX_W       = $clog2(MAX_ENTRIES),
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // store write port
    input  logic                         wr_en,
    input  logic [IDX_W:0]               wr_addr,
    input  logic [SCORE_BITS:0]          wr_data,
    // job queue
    input  logic                         job_empty,
    output logic                         job_pop,
    input  logic                         job_bank,
    input  logic [CNT_W-1:0]             job_count,
    input  logic signed [SCORE_BITS-1:0] job_min,
    input  logic signed [SCORE_BITS-1:0] job_max,
    input  logic                         job_hig,
    // results
    output logic                         empty,
    input  logic                         pop,
    output mmsn_pkg::out_item_t          result,
    output mmsn_pkg::done_t              done
);
    import mmsn_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_READ,
        S_PREP,
        S_DIV,
        S_OUT
    } state_t;

    // bank bit on top of the entry index, so each bank spans 2**IDX_W words
    logic [SCORE_BITS:0] mem [2**(IDX_W+1)];
    logic [SCORE_BITS:0] rd_data_reg;

    state_t                       state_reg;
    logic                         bank_reg;
    logic [CNT_W-1:0]             n_reg;
    logic signed [SCORE_BITS-1:0] min_reg;
    logic signed [SCORE_BITS-1:0] max_reg;
    logic                         hig_reg;
    logic [SCORE_BITS-1:0]        den_reg;
    logic                         degen_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic [SCORE_BITS:0]          rem_reg;
    logic [NORM_BITS-1:0]         q_reg;
    logic [STEP_BITS-1:0]         step_reg;
    logic                         out_valid_reg;
    out_item_t                    out_reg;
    done_t                        done_reg;

    logic signed [SCORE_BITS-1:0] v;
    logic                         v_inf;
    logic signed [SCORE_BITS:0]   v_x;
    logic signed [SCORE_BITS:0]   min_x;
    logic signed [SCORE_BITS:0]   max_x;
    logic signed [SCORE_BITS:0]   den_full;
    logic signed [SCORE_BITS:0]   diff;
    logic [SCORE_BITS-1:0]        num;
    logic                         rem_ge;
    logic [SCORE_BITS:0]          rem_sub;
    logic                         is_last;
    logic                         slot_free;
    logic                         load_out;

    // store: front end writes the filling bank, we read the emitting bank
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            rd_data_reg <= mem[{bank_reg, idx_reg}];
        end
    end

    assign v_inf = rd_data_reg[SCORE_BITS];
    assign v     = rd_data_reg[SCORE_BITS-1:0];
    assign v_x   = (SCORE_BITS+1)'(v);
    assign min_x = (SCORE_BITS+1)'(min_reg);
    assign max_x = (SCORE_BITS+1)'(max_reg);

    assign den_full = max_x - min_x;
    assign diff     = hig_reg ? (v_x - min_x) : (max_x - v_x);
    assign num      = diff[SCORE_BITS] ? '0 :
                      (diff[SCORE_BITS-1:0] > den_reg) ? den_reg : diff[SCORE_BITS-1:0];

    assign rem_ge  = rem_reg >= {1'b0, den_reg};
    assign rem_sub = rem_ge ? rem_reg - {1'b0, den_reg} : rem_reg;

    assign is_last   = (CNT_W'(idx_reg) + CNT_W'(1)) == n_reg;
    assign slot_free = !out_valid_reg || pop;
    assign load_out  = (state_reg == S_OUT) && slot_free;

    assign job_pop = (state_reg == S_IDLE) && !job_empty;
    assign empty   = !out_valid_reg;
    assign result  = out_reg;
    assign done    = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bank_reg      <= 1'b0;
            n_reg         <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            hig_reg       <= 1'b1;
            den_reg       <= '0;
            degen_reg     <= 1'b0;
            idx_reg       <= '0;
            rem_reg       <= '0;
            q_reg         <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            done_reg      <= '0;
        end
        else
        begin
            done_reg.valid <= load_out && is_last;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!job_empty)
                    begin
                        bank_reg  <= job_bank;
                        n_reg     <= job_count;
                        min_reg   <= job_min;
                        max_reg   <= job_max;
                        hig_reg   <= job_hig;
                        idx_reg   <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    den_reg   <= den_full[SCORE_BITS-1:0];
                    degen_reg <= max_reg <= min_reg;
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    // infinite and degenerate entries skip the divider
                    if (v_inf)
                    begin
                        q_reg     <= hig_reg ? FRAC_ONE : '0;
                        state_reg <= S_OUT;
                    end
                    else if (degen_reg)
                    begin
                        q_reg     <= FRAC_ONE;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        rem_reg   <= {1'b0, num};
                        q_reg     <= '0;
                        step_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg  <= {rem_sub[SCORE_BITS-1:0], 1'b0};
                    q_reg    <= {q_reg[NORM_BITS-2:0], rem_ge};
                    step_reg <= step_reg + STEP_BITS'(1);
                    if (step_reg == STEP_BITS'(DIV_STEPS - 1))
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (slot_free)
                    begin
                        out_reg.entry_index      <= INDEX_BITS'(idx_reg);
                        out_reg.normalized_score <= q_reg;
                        out_reg.last_result      <= is_last;
                        if (is_last)
                        begin
                            done_reg.bank <= bank_reg;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.normalized_score <= FRAC_ONE)
        else $error("normalized score above 1.0");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg.valid |-> out_valid_reg && out_reg.last_result)
        else $error("bank released before its last word was loaded");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < {den_reg, 1'b0})
        else $error("divider remainder out of range");

    a_out_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !pop) |=> state_reg == S_OUT)
        else $error("result overwritten while receiver stalls");

endmodule

// File: src/min_max_score_normalizer.sv
// Top level of the min/max score normalizer.
// Depends on mmsn_pkg, mmsn_front, mmsn_jobq and mmsn_back.
//
// Usage:
//   Input queue: drive item and raise push; a word is taken when push is high
//   and full is low. Each word stores one score (or a worst-case marker) in
//   load order, up to MAX_ENTRIES a set; the end_of_set word closes it.
//   Result queue: while empty is low, result carries the oldest normalized
//   entry; raise pop to take it. A closed set yields one result per stored
//   entry, in load order, last_result set on the final one.
//   Config channel: cfg_data is high_is_good, written when cfg_valid and
//   cfg_ready are both high; cfg_ready is always high. Write only while idle.
// Flow:
//   Loading takes in one word per cycle while full is low. The store has two
//   banks, so the next set loads while the previous one is emitted; full
//   rises only when both banks are taken. A closed set waits in the job
//   queue; the back end then loads its min/max and steps each entry through
//   read, prepare, the radix-2 divider and output. The divider is skipped
//   for worst-case markers while high_is_good is low, and when max <= min.
// Reset: clears the store bookkeeping, running min/max and both queues;
//   high_is_good returns to 1. Store contents are not cleared.
// Stall: if pop stays low, the back end holds the finished result and waits.
module min_max_score_normalizer #(
    parameter int MAX_ENTRIES = mmsn_pkg::DEF_MAX_ENTRIES,
    parameter int SCORE_BITS  = mmsn_pkg::DEF_SCORE_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  mmsn_pkg::in_item_t  item,
    output logic                empty,
    input  logic                pop,
    output mmsn_pkg::out_item_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);
    import mmsn_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic high_is_good_reg;

    // store write port, front to back
    logic                         wr_en;
    logic [IDX_W:0]               wr_addr;
    logic [SCORE_BITS:0]          wr_data;

    // job queue, both sides
    logic                         jq_push;
    logic                         jq_full;
    logic                         jq_in_bank;
    logic [CNT_W-1:0]             jq_in_count;
    logic signed [SCORE_BITS-1:0] jq_in_min;
    logic signed [SCORE_BITS-1:0] jq_in_max;
    logic                         jq_in_hig;
    logic                         jq_pop;
    logic                         jq_empty;
    logic                         jq_out_bank;
    logic [CNT_W-1:0]             jq_out_count;
    logic signed [SCORE_BITS-1:0] jq_out_min;
    logic signed [SCORE_BITS-1:0] jq_out_max;
    logic                         jq_out_hig;

    done_t                        done;

    // config register; always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_is_good_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            high_is_good_reg <= cfg_data;
        end
    end

    // front: accept words, fill the free bank, track min/max
    mmsn_front #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .SCORE_BITS  (SCORE_BITS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .item         (item),
        .high_is_good (high_is_good_reg),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .job_push     (jq_push),
        .job_full     (jq_full),
        .job_bank     (jq_in_bank),
        .job_count    (jq_in_count),
        .job_min      (jq_in_min),
        .job_max      (jq_in_max),
        .job_hig      (jq_in_hig),
        .done         (done)
    );

    // closed sets wait here until the back end is free
    mmsn_jobq #(
        .SCORE_BITS (SCORE_BITS),
        .CNT_W      (CNT_W)
    ) u_jobq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (jq_push),
        .full      (jq_full),
        .in_bank   (jq_in_bank),
        .in_count  (jq_in_count),
        .in_min    (jq_in_min),
        .in_max    (jq_in_max),
        .in_hig    (jq_in_hig),
        .pop       (jq_pop),
        .empty     (jq_empty),
        .out_bank  (jq_out_bank),
        .out_count (jq_out_count),
        .out_min   (jq_out_min),
        .out_max   (jq_out_max),
        .out_hig   (jq_out_hig)
    );

    // back: walk a bank, normalize and divide, drive the result queue
    mmsn_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .SCORE_BITS  (SCORE_BITS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .job_empty (jq_empty),
        .job_pop   (jq_pop),
        .job_bank  (jq_out_bank),
        .job_count (jq_out_count),
        .job_min   (jq_out_min),
        .job_max   (jq_out_max),
        .job_hig   (jq_out_hig),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .done      (done)
    );

endmodule
